@@ rtl/core/ircb_pkg.sv @@
package ircb_pkg;

   localparam int AddrW     = 32;
   localparam int PrefixW   = 6;
   localparam int Log2W     = 5;
   localparam int CountW    = 6;
   localparam int MaxBlocks = 62;

   // controller to datapath
   typedef struct packed {
      logic load;   // capture a new range
      logic step;   // emit one block into the output register, advance
   } ircb_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic empty;  // incoming range covers no address
      logic last;   // block computed this cycle closes the run
   } ircb_sts_type;

   // bit position of a one-hot word
   function automatic logic [Log2W-1:0] onehot_log2(input logic [AddrW-1:0] v);
      logic [Log2W-1:0] k;
      k = '0;
      for (int i = 0; i < AddrW; i++) begin
         if (v[i]) begin
            k = k | Log2W'(i);
         end
      end
      return k;
   endfunction

endpackage

@@ rtl/core/ircb_if.sv @@
interface ircb_req_if;
   logic                        valid;
   logic                        ready;
   logic [ircb_pkg::AddrW-1:0]  range_start;
   logic [ircb_pkg::AddrW-1:0]  range_end;

   modport source (output valid, range_start, range_end, input ready);
   modport sink   (input valid, range_start, range_end, output ready);
endinterface

interface ircb_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ircb_pkg::AddrW-1:0]    block_base;
   logic [ircb_pkg::AddrW-1:0]    block_mask;
   logic [ircb_pkg::PrefixW-1:0]  prefix_length;
   logic                          last_block;

   modport source (output valid, block_base, block_mask, prefix_length, last_block,
                   input ready);
   modport sink   (input valid, block_base, block_mask, prefix_length, last_block,
                   output ready);
endinterface

@@ rtl/core/ircb_dp.sv @@
module ircb_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  ircb_pkg::ircb_cmd_type        cmd,
   output ircb_pkg::ircb_sts_type        sts,
   input  logic [ircb_pkg::AddrW-1:0]    range_start,
   input  logic [ircb_pkg::AddrW-1:0]    range_end,
   output logic [ircb_pkg::AddrW-1:0]    block_base,
   output logic [ircb_pkg::AddrW-1:0]    block_mask,
   output logic [ircb_pkg::PrefixW-1:0]  prefix_length,
   output logic                          last_block
);

   logic [ircb_pkg::AddrW-1:0]   lo_ff, lo_in;
   logic [ircb_pkg::AddrW-1:0]   remain_ff, remain_in;
   logic [ircb_pkg::CountW-1:0]  cnt_ff, cnt_in;

   logic [ircb_pkg::AddrW-1:0]   base_ff, mask_ff;
   logic [ircb_pkg::PrefixW-1:0] prefix_ff;
   logic                         last_ff;

   logic [ircb_pkg::AddrW-1:0]   start_adj;
   logic [ircb_pkg::AddrW-1:0]   low_bit, smear, top_bit, size;
   logic                         use_low, done;
   logic [ircb_pkg::Log2W-1:0]   size_log2;

   function automatic logic [ircb_pkg::AddrW-1:0] ipv4_one_val();
      logic [ircb_pkg::AddrW-1:0] v;
      v    = '0;
      v[0] = 1'b1;
      return v;
   endfunction
   function automatic logic [ircb_pkg::AddrW-1:0] ipv4_one();
      return ipv4_one_val();
   endfunction

   // address zero is never covered
   assign start_adj = (range_start == '0) ? ipv4_one() : range_start;
   assign sts.empty = range_end < start_adj;

   // alignment of the current base
   assign low_bit = lo_ff & (~lo_ff + ipv4_one());

   // largest power of two not above the remaining count
   always_comb begin
      smear = remain_ff;
      smear = smear | (smear >> 1);
      smear = smear | (smear >> 2);
      smear = smear | (smear >> 4);
      smear = smear | (smear >> 8);
      smear = smear | (smear >> 16);
   end
   assign top_bit = smear ^ (smear >> 1);

   assign use_low   = |(low_bit & smear);
   assign size      = use_low ? low_bit : top_bit;
   assign size_log2 = ircb_pkg::onehot_log2(size);
   assign done      = (size == remain_ff);
   assign sts.last  = done || (cnt_ff == ircb_pkg::CountW'(ircb_pkg::MaxBlocks - 1));

   always_comb begin
      lo_in     = lo_ff;
      remain_in = remain_ff;
      cnt_in    = cnt_ff;
      if (cmd.load) begin
         lo_in     = start_adj;
         remain_in = range_end - start_adj + ipv4_one();
         cnt_in    = '0;
      end else if (cmd.step) begin
         lo_in     = lo_ff + size;
         remain_in = remain_ff - size;
         cnt_in    = cnt_ff + ircb_pkg::CountW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      lo_ff     <= lo_in;
      remain_ff <= remain_in;
      if (cmd.step) begin
         base_ff   <= lo_ff;
         mask_ff   <= ~(size - ipv4_one());
         prefix_ff <= ircb_pkg::PrefixW'(ircb_pkg::AddrW) - {1'b0, size_log2};
         last_ff   <= sts.last;
      end
   end

   assign block_base    = base_ff;
   assign block_mask    = mask_ff;
   assign prefix_length = prefix_ff;
   assign last_block    = last_ff;

endmodule

@@ rtl/core/ircb_ctrl.sv @@
module ircb_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output ircb_pkg::ircb_cmd_type  cmd,
   input  ircb_pkg::ircb_sts_type  sts
);

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign cmd.load  = req_valid && req_ready;
   // advance when the output register is free or drains this cycle
   assign cmd.step  = (state_ff == ST_RUN) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.load && !sts.empty) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (cmd.step && sts.last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = cmd.step || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/core/ipv4_range_to_cidr_blocks_core.sv @@
// Channel   Dir  Payload                                             Transfer
// req_ch    in   range_start[31:0], range_end[31:0]                  valid & ready
// rsp_ch    out  block_base[31:0], block_mask[31:0],                 valid & ready
//                prefix_length[5:0], last_block
//
// A range is accepted while idle; then the single-step block loop over the base
// and remaining-count registers in the datapath emits one block per cycle while
// rsp_ch drains, at most 62 blocks per range.
// A range that covers no address is accepted and yields no block.
// A stalled rsp_ch holds the output register and freezes the loop.
// Reset is synchronous, active high; it idles the controller.
module ipv4_range_to_cidr_blocks_core (
   input  logic        clock,
   input  logic        reset,
   ircb_req_if.sink    req_ch,
   ircb_rsp_if.source  rsp_ch
);

   ircb_pkg::ircb_cmd_type cmd;
   ircb_pkg::ircb_sts_type sts;

   // sequence accept, block steps and the output handshake
   ircb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // hold the current base and remaining count, size one block per step
   ircb_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .range_start   (req_ch.range_start),
      .range_end     (req_ch.range_end),
      .block_base    (rsp_ch.block_base),
      .block_mask    (rsp_ch.block_mask),
      .prefix_length (rsp_ch.prefix_length),
      .last_block    (rsp_ch.last_block)
   );

endmodule

@@ rtl/core/ircb_checker.sv @@
module ircb_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [ircb_pkg::AddrW-1:0]    block_base,
   input logic [ircb_pkg::AddrW-1:0]    block_mask,
   input logic [ircb_pkg::PrefixW-1:0]  prefix_length,
   input logic                          last_block
);

   // a stalled block holds until transferred
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(block_base) &&
      $stable(block_mask) && $stable(prefix_length) && $stable(last_block))
      else $error("rsp block changed while stalled");

   a_prefix_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (prefix_length >= 6'd1) && (prefix_length <= 6'd32))
      else $error("prefix length out of range");

   a_mask_prefix: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> block_mask == (32'hFFFF_FFFF << (6'd32 - prefix_length)))
      else $error("mask does not match prefix length");

   a_base_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (block_base & ~block_mask) == 32'd0)
      else $error("block base not aligned to its mask");

endmodule

bind ipv4_range_to_cidr_blocks_core ircb_checker u_ircb_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .block_base    (rsp_ch.block_base),
   .block_mask    (rsp_ch.block_mask),
   .prefix_length (rsp_ch.prefix_length),
   .last_block    (rsp_ch.last_block)
);
